[hdl/ssts_pkg.sv]
// Shared types, constants and font functions for the seven-segment text scanner.
// Used by the top level and the testbench; depends on nothing.
package ssts_pkg;

   // Number of multiplexed digits on the display
   localparam int DIGIT_COUNT = 4;
   localparam int DIGIT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int TEXT_POS_W  = $clog2(DIGIT_COUNT + 1);

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_DISPLAY_ENABLE = 3'd0;

   // Function codes of an input beat
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_CHAR  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_HEX   = 2'd3;

   // Segment bits
   localparam logic [7:0] SG_A  = 8'h01;
   localparam logic [7:0] SG_B  = 8'h02;
   localparam logic [7:0] SG_C  = 8'h04;
   localparam logic [7:0] SG_D  = 8'h08;
   localparam logic [7:0] SG_E  = 8'h10;
   localparam logic [7:0] SG_F  = 8'h20;
   localparam logic [7:0] SG_G  = 8'h40;
   localparam logic [7:0] SG_DP = 8'h80;

   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] LAST_GLYPH_CODE = 8'd122;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  char_code;
      logic        string_start;
      logic [15:0] hex_value;
   } req_type;

   typedef struct packed {
      logic [3:0] digit_lines;
      logic [7:0] segment_lines;
      logic       drive_on;
   } rsp_type;

   // Glyph of one hex nibble
   function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
      logic [7:0] g;
      unique case (nib)
         4'h0: g = SG_A|SG_B|SG_C|SG_D|SG_E|SG_F;
         4'h1: g = SG_B|SG_C;
         4'h2: g = SG_A|SG_B|SG_D|SG_E|SG_G;
         4'h3: g = SG_A|SG_B|SG_C|SG_D|SG_G;
         4'h4: g = SG_B|SG_C|SG_F|SG_G;
         4'h5: g = SG_A|SG_C|SG_D|SG_F|SG_G;
         4'h6: g = SG_A|SG_C|SG_D|SG_E|SG_F|SG_G;
         4'h7: g = SG_A|SG_B|SG_C;
         4'h8: g = SG_A|SG_B|SG_C|SG_D|SG_E|SG_F|SG_G;
         4'h9: g = SG_A|SG_B|SG_C|SG_D|SG_F|SG_G;
         4'hA: g = SG_A|SG_B|SG_C|SG_E|SG_F|SG_G;
         4'hB: g = SG_C|SG_D|SG_E|SG_F|SG_G;
         4'hC: g = SG_A|SG_D|SG_E|SG_F;
         4'hD: g = SG_B|SG_C|SG_D|SG_E|SG_G;
         4'hE: g = SG_A|SG_D|SG_E|SG_F|SG_G;
         default: g = SG_A|SG_E|SG_F|SG_G;
      endcase
      return g;
   endfunction

   // ASCII font; codes without a glyph show blank
   function automatic logic [7:0] char_glyph(input logic [7:0] c);
      logic [7:0] g;
      if (c > LAST_GLYPH_CODE) begin
         g = 8'h00;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         g = hex_glyph(c[3:0]);
      end else begin
         unique case (c)
            8'h2D: g = SG_G;              // '-'
            8'h2E: g = SG_DP;             // '.'
            8'h5F: g = SG_D;              // '_'
            8'h41: g = hex_glyph(4'hA);   // 'A'
            8'h43: g = hex_glyph(4'hC);   // 'C'
            8'h45: g = hex_glyph(4'hE);   // 'E'
            8'h46: g = hex_glyph(4'hF);   // 'F'
            8'h47: g = SG_A|SG_C|SG_D|SG_E|SG_F;
            8'h48: g = SG_B|SG_C|SG_E|SG_F|SG_G;
            8'h49: g = SG_B|SG_C;
            8'h4A: g = SG_B|SG_C|SG_D;
            8'h4C: g = SG_D|SG_E|SG_F;
            8'h4F: g = SG_A|SG_B|SG_C|SG_D|SG_E|SG_F;
            8'h50: g = SG_A|SG_B|SG_E|SG_F|SG_G;
            8'h53: g = SG_A|SG_C|SG_D|SG_F|SG_G;
            8'h55: g = SG_B|SG_C|SG_D|SG_E|SG_F;
            8'h62: g = hex_glyph(4'hB);   // 'b'
            8'h63: g = SG_D|SG_E|SG_G;
            8'h64: g = hex_glyph(4'hD);   // 'd'
            8'h67: g = SG_A|SG_B|SG_C|SG_D|SG_F|SG_G;
            8'h68: g = SG_C|SG_E|SG_F|SG_G;
            8'h6E: g = SG_C|SG_E|SG_G;
            8'h6F: g = SG_C|SG_D|SG_E|SG_G;
            8'h70: g = SG_A|SG_B|SG_E|SG_F|SG_G;
            8'h71: g = SG_A|SG_B|SG_C|SG_F|SG_G;
            8'h72: g = SG_E|SG_G;
            8'h74: g = SG_D|SG_E|SG_F|SG_G;
            8'h75: g = SG_C|SG_D|SG_E;
            8'h79: g = SG_B|SG_C|SG_D|SG_F|SG_G;
            default: g = 8'h00;
         endcase
      end
      return g;
   endfunction

endpackage

[hdl/seven_segment_text_scanner_unit.sv]
// Top level of the seven-segment text scanner: input decode, digit flags,
// glyph RAM and scan output stage. Depends on ssts_pkg and ssts_ram.
//
// Usage:
//   The req channel carries one command beat per cycle unless stalled: a scan
//   tick, a text character, a clear or a hex value. Only a tick yields a rsp
//   beat, holding the active-low digit and segment lines for the current digit;
//   if enabled, the scan then moves to the next digit. Text, clear and hex beats
//   only update the display buffer.
//   A tick passes the glyph RAM read, then the output register, before its rsp
//   beat shows. Throughput is one beat per cycle while rsp is not stalled, set
//   by the single glyph RAM read port and the output register.
//   When rsp_stall is high with a result held, req_stall rises in the same
//   cycle and the whole pipe holds; nothing is lost or repeated.
//   Reset clears the digit valid flags (display blank), text position, scan
//   digit and display enable. No clearing pass: per-digit valid bits blank
//   digits whose glyph was never written.
//   The APB-style port holds display_enable at address 0. Writing zero while
//   enabled blanks the buffer; ticks while disabled return released lines.
module seven_segment_text_scanner_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Command channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ssts_pkg::req_type                   req_data,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ssts_pkg::rsp_type                   rsp_data,
   // Configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ssts_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ssts_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ssts_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import ssts_pkg::*;

   // Control state
   logic                   enable_ff, enable_in;
   logic [DIGIT_IDX_W-1:0] scan_ff, scan_in;
   logic [TEXT_POS_W-1:0]  pos_ff, pos_in;
   logic                   stopped_ff, stopped_in;
   logic [DIGIT_COUNT-1:0] entry_valid_ff, entry_valid_in;
   logic [DIGIT_COUNT-1:0] entry_hex_ff, entry_hex_in;
   logic [DIGIT_COUNT-1:0] entry_dp_ff, entry_dp_in;
   logic [15:0]            hex_ff, hex_in;

   // Read stage
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_enable_ff;
   logic [DIGIT_IDX_W-1:0] s1_scan_ff;
   logic                   s1_entry_valid_ff, s1_entry_hex_ff, s1_entry_dp_ff;
   logic [7:0]             s1_hex_glyph_ff;

   // Output stage
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff, rsp_data_in;

   // Glyph RAM ports
   logic                   ram_wr_en;
   logic [DIGIT_IDX_W-1:0] ram_wr_addr;
   logic [7:0]             ram_wr_data;
   logic                   ram_rd_en;
   logic [7:0]             ram_rd_data;

   logic                   advance;
   logic                   accept;
   logic                   cfg_write;
   logic [3:0]             hex_nibble;
   logic [7:0]             hex_glyph_now;

   // Pipe moves whenever the output register is free or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign cfg_write = psel && penable && pwrite && pready;

   // Configuration read back
   assign pready = 1'b1;
   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1:2] == ADDR_DISPLAY_ENABLE[CSR_ADDR_W-1:2]) begin
         prdata[0] = enable_ff;
      end
   end

   ssts_ram #(
      .WIDTH(8),
      .DEPTH(DIGIT_COUNT)
   ) glyph_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_ff),
      .rd_data (ram_rd_data)
   );

   // Hex glyph of the digit under scan; digits past four nibbles show zero
   always_comb begin
      hex_nibble = 4'h0;
      for (int n = 0; n < 4; n++) begin
         if (int'(scan_ff) == DIGIT_COUNT - 1 - n) begin
            hex_nibble = hex_ff[4*n +: 4];
         end
      end
      hex_glyph_now = hex_glyph(hex_nibble);
   end

   // Decode the command beat and update flags, position and glyph RAM
   always_comb begin
      logic                   stopped_e;
      logic [TEXT_POS_W-1:0]  pos_e;
      logic [DIGIT_IDX_W-1:0] dot_idx;
      logic [DIGIT_IDX_W-1:0] pos_idx;

      enable_in      = enable_ff;
      scan_in        = scan_ff;
      pos_in         = pos_ff;
      stopped_in     = stopped_ff;
      entry_valid_in = entry_valid_ff;
      entry_hex_in   = entry_hex_ff;
      entry_dp_in    = entry_dp_ff;
      hex_in         = hex_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_wr_data    = 8'h00;
      ram_rd_en      = 1'b0;
      s1_valid_in    = s1_valid_ff;

      stopped_e = stopped_ff;
      pos_e     = pos_ff;
      pos_idx   = pos_e[DIGIT_IDX_W-1:0];
      dot_idx   = pos_idx - 1'b1;

      if (advance) begin
         s1_valid_in = accept && (req_data.func == FUNC_TICK);
      end

      if (accept) begin
         unique case (req_data.func)
            FUNC_TICK: begin
               ram_rd_en = 1'b1;
               if (enable_ff) begin
                  scan_in = (int'(scan_ff) == DIGIT_COUNT - 1) ? '0 : scan_ff + 1'b1;
               end
            end
            FUNC_CHAR: begin
               // A string start blanks the buffer and rewinds the text
               if (req_data.string_start) begin
                  entry_valid_in = '0;
                  stopped_e      = 1'b0;
                  pos_e          = '0;
               end
               pos_idx = pos_e[DIGIT_IDX_W-1:0];
               dot_idx = pos_idx - 1'b1;
               stopped_in = stopped_e;
               pos_in     = pos_e;
               if (!stopped_e) begin
                  if (pos_e != '0 && req_data.char_code == CHAR_DOT) begin
                     // Light the dot of the previous digit
                     entry_dp_in[dot_idx] = 1'b1;
                     if (!entry_valid_in[dot_idx]) begin
                        ram_wr_en                = 1'b1;
                        ram_wr_addr              = dot_idx;
                        ram_wr_data              = 8'h00;
                        entry_valid_in[dot_idx]  = 1'b1;
                        entry_hex_in[dot_idx]    = 1'b0;
                     end
                  end else if (int'(pos_e) < DIGIT_COUNT) begin
                     ram_wr_en               = 1'b1;
                     ram_wr_addr             = pos_idx;
                     ram_wr_data             = char_glyph(req_data.char_code);
                     entry_valid_in[pos_idx] = 1'b1;
                     entry_hex_in[pos_idx]   = 1'b0;
                     entry_dp_in[pos_idx]    = 1'b0;
                     pos_in                  = pos_e + 1'b1;
                  end else begin
                     stopped_in = 1'b1;
                  end
               end
            end
            FUNC_CLEAR: begin
               entry_valid_in = '0;
            end
            FUNC_HEX: begin
               entry_valid_in = '1;
               entry_hex_in   = '1;
               entry_dp_in    = '0;
               hex_in         = req_data.hex_value;
            end
            default: begin
            end
         endcase
      end

      // Enable register; disabling blanks the buffer
      if (cfg_write && paddr[CSR_ADDR_W-1:2] == ADDR_DISPLAY_ENABLE[CSR_ADDR_W-1:2]) begin
         if (pwdata[0]) begin
            enable_in = 1'b1;
         end else if (enable_ff) begin
            enable_in      = 1'b0;
            entry_valid_in = '0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         scan_ff        <= '0;
         pos_ff         <= '0;
         stopped_ff     <= 1'b0;
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         enable_ff      <= enable_in;
         scan_ff        <= scan_in;
         pos_ff         <= pos_in;
         stopped_ff     <= stopped_in;
         entry_valid_ff <= entry_valid_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   // Payload flags and hex value
   always_ff @(posedge clock) begin
      entry_hex_ff <= entry_hex_in;
      entry_dp_ff  <= entry_dp_in;
      hex_ff       <= hex_in;
   end

   // Capture the scanned digit's flags alongside the RAM read
   always_ff @(posedge clock) begin
      if (accept && req_data.func == FUNC_TICK) begin
         s1_enable_ff      <= enable_ff;
         s1_scan_ff        <= scan_ff;
         s1_entry_valid_ff <= entry_valid_ff[scan_ff];
         s1_entry_hex_ff   <= entry_hex_ff[scan_ff];
         s1_entry_dp_ff    <= entry_dp_ff[scan_ff];
         s1_hex_glyph_ff   <= hex_glyph_now;
      end
   end

   // Assemble the result beat
   always_comb begin
      logic [7:0] seg;
      seg = 8'h00;
      if (s1_entry_valid_ff) begin
         seg = (s1_entry_hex_ff ? s1_hex_glyph_ff : ram_rd_data)
               | (s1_entry_dp_ff ? SG_DP : 8'h00);
      end
      if (s1_enable_ff) begin
         for (int i = 0; i < 4; i++) begin
            rsp_data_in.digit_lines[i] = (int'(s1_scan_ff) != i);
         end
         rsp_data_in.segment_lines = ~seg;
         rsp_data_in.drive_on      = 1'b1;
      end else begin
         rsp_data_in.digit_lines   = 4'hF;
         rsp_data_in.segment_lines = 8'hFF;
         rsp_data_in.drive_on      = 1'b0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Text position never passes the digit count
   assert property (@(posedge clock) disable iff (reset)
      int'(pos_ff) <= DIGIT_COUNT)
      else $error("text position out of range");

   // Released pins always come with all lines high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.drive_on
      |-> rsp_data_ff.digit_lines == 4'hF && rsp_data_ff.segment_lines == 8'hFF)
      else $error("released beat drives lines");

   // A driven beat selects at most one digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.drive_on |-> $onehot0(~rsp_data_ff.digit_lines))
      else $error("more than one digit selected");

   // An accepted tick enters the read stage at the next edge
   assert property (@(posedge clock) disable iff (reset)
      accept && req_data.func == FUNC_TICK |=> s1_valid_ff)
      else $error("tick lost in read stage");

   // The scan digit moves only on an enabled tick
   assert property (@(posedge clock) disable iff (reset)
      !(accept && req_data.func == FUNC_TICK && enable_ff) |=> $stable(scan_ff))
      else $error("scan digit moved without a tick");

endmodule

[hdl/ssts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module ssts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read; hold the last word while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/tb_seven_segment_text_scanner_unit.sv]
// Testbench for seven_segment_text_scanner_unit: random and directed command beats
// against a scoreboard that predicts every scan result. Depends on ssts_pkg.
module tb_seven_segment_text_scanner_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ssts_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_BEATS    = 150;
   localparam int PHASE_COUNT    = 8;
   // Address of a register index beyond the only one
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

   // Predicts the lines of each scan tick and checks them in order
   class display_scoreboard;
      logic [7:0]  seg_buf [DIGIT_COUNT];
      int unsigned scan_pos;
      int unsigned text_pos;
      bit          text_halted;
      bit          enabled;
      rsp_type     lines_due [$];
      int unsigned failures;

      function new();
         blank();
         scan_pos    = 0;
         text_pos    = 0;
         text_halted = 0;
         enabled     = 0;
         failures    = 0;
      endfunction

      function void blank();
         foreach (seg_buf[k]) seg_buf[k] = 8'h00;
      endfunction

      function logic [7:0] nibble_segments(input logic [3:0] nib);
         case (nib)
            4'h0: return 8'h3F;
            4'h1: return 8'h06;
            4'h2: return 8'h5B;
            4'h3: return 8'h4F;
            4'h4: return 8'h66;
            4'h5: return 8'h6D;
            4'h6: return 8'h7D;
            4'h7: return 8'h07;
            4'h8: return 8'h7F;
            4'h9: return 8'h6F;
            4'hA: return 8'h77;
            4'hB: return 8'h7C;
            4'hC: return 8'h39;
            4'hD: return 8'h5E;
            4'hE: return 8'h79;
            default: return 8'h71;
         endcase
      endfunction

      function logic [7:0] text_segments(input logic [7:0] c);
         if (c >= "0" && c <= "9") return nibble_segments(c[3:0]);
         case (c)
            "-": return 8'h40;
            ".": return 8'h80;
            "_": return 8'h08;
            "A": return 8'h77;
            "C": return 8'h39;
            "E": return 8'h79;
            "F": return 8'h71;
            "G": return 8'h3D;
            "H": return 8'h76;
            "I": return 8'h06;
            "J": return 8'h0E;
            "L": return 8'h38;
            "O": return 8'h3F;
            "P": return 8'h73;
            "S": return 8'h6D;
            "U": return 8'h3E;
            "b": return 8'h7C;
            "c": return 8'h58;
            "d": return 8'h5E;
            "g": return 8'h6F;
            "h": return 8'h74;
            "n": return 8'h54;
            "o": return 8'h5C;
            "p": return 8'h73;
            "q": return 8'h67;
            "r": return 8'h50;
            "t": return 8'h78;
            "u": return 8'h1C;
            "y": return 8'h6E;
            default: return 8'h00;
         endcase
      endfunction

      // Track a register write
      function void apply_config(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] value);
         if (addr != ADDR_DISPLAY_ENABLE) return;
         if (value[0]) begin
            enabled = 1;
         end else if (enabled) begin
            blank();
            enabled = 0;
         end
      endfunction

      // Update the display state for one accepted command beat
      function void note_beat(input req_type b);
         rsp_type lines;
         int unsigned nib;
         case (b.func)
            FUNC_CHAR: begin
               if (b.string_start) begin
                  blank();
                  text_pos    = 0;
                  text_halted = 0;
               end
               if (!text_halted) begin
                  if (text_pos > 0 && b.char_code == CHAR_DOT) begin
                     seg_buf[text_pos - 1] |= SG_DP;
                  end else if (text_pos < DIGIT_COUNT) begin
                     seg_buf[text_pos] = text_segments(b.char_code);
                     text_pos++;
                  end else begin
                     text_halted = 1;
                  end
               end
            end
            FUNC_CLEAR: blank();
            FUNC_HEX: begin
               for (int k = 0; k < DIGIT_COUNT; k++) begin
                  nib = DIGIT_COUNT - 1 - k;
                  seg_buf[k] = (nib < 4) ? nibble_segments(b.hex_value[4*nib +: 4])
                                         : nibble_segments(4'h0);
               end
            end
            FUNC_TICK: begin
               if (!enabled) begin
                  lines.digit_lines   = 4'hF;
                  lines.segment_lines = 8'hFF;
                  lines.drive_on      = 1'b0;
               end else begin
                  lines.digit_lines   = 4'hF & ~(4'b0001 << scan_pos);
                  lines.segment_lines = ~seg_buf[scan_pos];
                  lines.drive_on      = 1'b1;
                  scan_pos = (scan_pos + 1) % DIGIT_COUNT;
               end
               lines_due.push_back(lines);
            end
            default: ;
         endcase
      endfunction

      // Compare one result beat with the oldest prediction
      function void check_beat(input rsp_type got);
         rsp_type want;
         if (lines_due.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result beat: %h/%h/%b",
                        got.digit_lines, got.segment_lines, got.drive_on);
            return;
         end
         want = lines_due.pop_front();
         if (got.digit_lines !== want.digit_lines ||
             got.segment_lines !== want.segment_lines ||
             got.drive_on !== want.drive_on) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: digit %h/%h segments %h/%h drive %b/%b (expected/actual)",
                        want.digit_lines, got.digit_lines, want.segment_lines,
                        got.segment_lines, want.drive_on, got.drive_on);
         end
      endfunction

      function int unsigned pending();
         return lines_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   display_scoreboard sb = new();

   bit          no_idle  = 0;
   bit          hold_req = 0;
   int unsigned hold_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned beats_sent = 0;
   string       char_pool = "0123456789-._ACEFGHIJLOPSUbcdghnopqrtuyKMz{";

   seven_segment_text_scanner_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random stalls, a long hold-off on request, none in quiet phases
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 13);
         end
      end
   end

   // Check each accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_beat(rsp_data);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one beat, with a random gap ahead of it, and hold it until accepted
   task automatic send_beat(input req_type b);
      if (!no_idle) begin
         while ($urandom_range(99) < 13) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      sb.note_beat(b);
      beats_sent++;
   endtask

   // Drop valid and wait until every predicted result has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.apply_config(addr, value);
   endtask

   function automatic req_type make_beat(input logic [1:0] f);
      req_type b;
      b.func         = f;
      b.char_code    = 8'($urandom);
      b.string_start = 1'($urandom);
      b.hex_value    = 16'($urandom);
      return b;
   endfunction

   task automatic send_char(input logic [7:0] c, input logic start);
      req_type b;
      b = make_beat(FUNC_CHAR);
      b.char_code    = c;
      b.string_start = start;
      send_beat(b);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_beat(make_beat(FUNC_TICK));
   endtask

   // One random unit of traffic: mostly whole strings followed by a scan
   task automatic send_random_unit();
      int unsigned pick;
      int unsigned len;
      req_type     b;
      pick = $urandom_range(99);
      if (pick < 60) begin
         len = $urandom_range(7, 1);
         for (int k = 0; k < len; k++) begin
            b = make_beat(FUNC_CHAR);
            b.string_start = (k == 0);
            if ($urandom_range(3) == 0)
               b.char_code = CHAR_DOT;
            else if ($urandom_range(4) != 0)
               b.char_code = char_pool[$urandom_range(char_pool.len() - 1)];
            send_beat(b);
         end
         send_ticks($urandom_range(8, 2));
      end else if (pick < 75) begin
         send_beat(make_beat(FUNC_HEX));
         send_ticks($urandom_range(6, 1));
      end else if (pick < 80) begin
         send_beat(make_beat(FUNC_CLEAR));
         send_ticks($urandom_range(3, 1));
      end else begin
         send_beat(make_beat(2'($urandom)));
      end
   endtask

   initial begin
      req_type     b;
      int unsigned phase_end;
      bit          paused;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: tick and hex write while disabled
      send_ticks(1);
      b = make_beat(FUNC_HEX);
      b.hex_value = 16'h0000;
      send_beat(b);
      drain();
      csr_write(ADDR_DISPLAY_ENABLE, 32'h0000_0001);
      send_ticks(4);

      // Leading dot, dot on a digit, unmapped codes, full buffer, stop
      send_char(CHAR_DOT, 1'b1);
      send_char(CHAR_DOT, 1'b0);
      send_char("A", 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(CHAR_DOT, 1'b0);
      send_char("8", 1'b0);
      send_char("1", 1'b0);
      send_ticks(4);
      send_beat(make_beat(FUNC_CLEAR));
      send_ticks(1);
      b = make_beat(FUNC_HEX);
      b.hex_value = 16'hFFFF;
      send_beat(b);
      send_ticks(1);
      send_char("K", 1'b1);
      send_ticks(1);

      // Random phases, each behind a register write
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         case (p)
            2: csr_write(ADDR_DISPLAY_ENABLE, 32'h0000_0000);
            3: begin
               csr_write(ADDR_DISPLAY_ENABLE, 32'hFFFF_FFFF);
               csr_write(ADDR_UNUSED, 32'h0000_0000);
            end
            5: csr_write(ADDR_DISPLAY_ENABLE, 32'hFFFF_FFFE);
            6: begin
               csr_write(ADDR_DISPLAY_ENABLE, 32'h0000_0001);
               csr_write(ADDR_DISPLAY_ENABLE, 32'hFFFF_FFFF);
            end
            default: csr_write(ADDR_DISPLAY_ENABLE, 32'h0000_0001);
         endcase
         no_idle = (p == 3);
         if (p == 1) hold_req = 1;
         paused = 0;
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) begin
            send_random_unit();
            // Pause the sender once until every result is out
            if (p == 4 && !paused && beats_sent + PHASE_BEATS / 2 >= phase_end) begin
               drain();
               paused = 1;
            end
         end
      end
      no_idle = 0;

      drain();
      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
